[rtl/gtj_pkg.sv]
package gtj_pkg;

  localparam int unsigned LineMax   = 32;
  localparam int unsigned GapsMax   = 16;
  localparam int unsigned WidthBits = 6;
  localparam int unsigned PosBits   = $clog2(LineMax);
  localparam int unsigned WordBits  = $clog2(GapsMax);
  localparam logic [7:0]  SpaceChar = 8'h20;
  localparam logic [WidthBits-1:0] WidthReset = 6'd16;

  typedef struct packed {
    logic [7:0] ch;
    logic       we;
    logic       te;
  } item_t;

  typedef struct packed {
    logic valid;
  } queue_ctrl_t;

endpackage

[rtl/gtj_front.sv]
module gtj_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_char_i,
  input  logic          in_word_end_i,
  input  logic          in_text_end_i,
  input  logic          pop_i,
  output logic          item_valid_o,
  output gtj_pkg::item_t item_o
);
  import gtj_pkg::*;

  item_t       mem_q [2];
  logic        wr_q, wr_d, rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;
  item_t       cls;

  assign in_ready_o   = (cnt_q != 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rd_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = pop_i && item_valid_o;

  // A text end also closes the current word.
  always_comb begin
    cls.ch = in_char_i;
    cls.we = in_word_end_i | in_text_end_i;
    cls.te = in_text_end_i;
    wr_d   = push ? ~wr_q : wr_q;
    rd_d   = pop ? ~rd_q : rd_q;
    cnt_d  = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[rtl/gtj_back.sv]
module gtj_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [gtj_pkg::WidthBits-1:0] width_i,
  input  gtj_pkg::queue_ctrl_t        q_i,
  output logic                        pop_o,
  input  gtj_pkg::item_t              item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  out_char_o,
  output logic                        out_line_end_o,
  output logic                        out_last_o,
  output logic                        out_trunc_o
);
  import gtj_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WEND = 3'd1;
  localparam logic [2:0] S_COPY = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  localparam logic [1:0] PH_WORD = 2'd0;
  localparam logic [1:0] PH_GAP  = 2'd1;
  localparam logic [1:0] PH_PAD  = 2'd2;

  logic [7:0]           word_mem [LineMax];
  logic [7:0]           line_mem [LineMax];
  logic [WidthBits-1:0] len_mem  [GapsMax];

  logic [2:0] st_q, st_d;
  logic [1:0] ph_q, ph_d;
  logic [WidthBits-1:0] wlen_q, wlen_d, wl_q, wl_d, used_q, used_d, chars_q, chars_d;
  logic [WidthBits-1:0] k_q, k_d, gcnt_q, gcnt_d, done_q, done_d, total_q, total_d;
  logic [4:0] wil_q, wil_d, i_q, i_d, rem_q, rem_d, base_q, base_d;
  logic [PosBits-1:0] pos_q, pos_d;
  logic cut_q, cut_d, te_q, te_d, trunc_q, trunc_d, just_q, just_d, full_q, full_d;
  logic ov_q, ov_d, ole_q, ole_d, olast_q, olast_d;
  logic [7:0] och_q, och_d;
  logic otr_q, otr_d;

  logic adv, emit, le;
  logic [7:0] ech;
  logic word_wr, line_wr, len_wr;
  logic [WidthBits-1:0] wl_c, len_c;
  logic [6:0] need;
  logic [4:0] gaps;

  assign adv  = !ov_q || out_ready_i;
  assign gaps = wil_q - 5'd1;
  assign len_c = len_mem[i_q[WordBits-1:0]];
  assign le   = ((done_q + 6'd1) == total_q);

  assign out_valid_o    = ov_q;
  assign out_char_o     = och_q;
  assign out_line_end_o = ole_q;
  assign out_last_o     = olast_q;
  assign out_trunc_o    = otr_q;

  always_comb begin
    st_d = st_q; ph_d = ph_q; wlen_d = wlen_q; wl_d = wl_q; used_d = used_q;
    chars_d = chars_q; k_d = k_q; gcnt_d = gcnt_q; done_d = done_q; total_d = total_q;
    wil_d = wil_q; i_d = i_q; rem_d = rem_q; base_d = base_q; pos_d = pos_q;
    cut_d = cut_q; te_d = te_q; trunc_d = trunc_q; just_d = just_q; full_d = full_q;
    pop_o = 1'b0; emit = 1'b0; ech = SpaceChar;
    word_wr = 1'b0; line_wr = 1'b0; len_wr = 1'b0;
    wl_c = (wlen_q > width_i) ? width_i : wlen_q;
    need = {1'b0, used_q} + 7'd1 + {1'b0, wl_c};

    case (st_q)
      S_IDLE: begin
        if (q_i.valid) begin
          pop_o = 1'b1;
          te_d  = item_i.te;
          if (wlen_q < width_i) begin
            word_wr = 1'b1;
            wlen_d  = wlen_q + 6'd1;
          end else begin
            cut_d = 1'b1;
          end
          if (item_i.we) begin
            st_d = S_WEND;
          end
        end
      end
      S_WEND: begin
        wl_d = wl_c;
        if (wlen_q > width_i) begin
          cut_d = 1'b1;
        end
        k_d = '0;
        if (wil_q != 5'd0 && need > {1'b0, width_i}) begin
          just_d = 1'b1;
          st_d   = S_DIV;
        end else begin
          st_d = S_COPY;
        end
      end
      S_COPY: begin
        if (k_q < wl_q) begin
          line_wr = 1'b1;
          k_d     = k_q + 6'd1;
        end else begin
          len_wr  = 1'b1;
          used_d  = used_q + {5'd0, wil_q != 5'd0} + wl_q;
          wil_d   = wil_q + 5'd1;
          chars_d = chars_q + wl_q;
          trunc_d = trunc_q | cut_q;
          cut_d   = 1'b0;
          wlen_d  = '0;
          if (te_q) begin
            just_d = 1'b0;
            st_d   = S_DIV;
          end else begin
            st_d = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (full_q && rem_q >= gaps) begin
          rem_d  = rem_q - gaps;
          base_d = base_q + 5'd1;
        end else begin
          st_d   = S_EMIT;
          ph_d   = PH_WORD;
          i_d    = '0;
          k_d    = '0;
          pos_d  = '0;
          done_d = '0;
        end
      end
      S_EMIT: begin
        if (adv) begin
          case (ph_q)
            PH_WORD: begin
              if (k_q < len_c) begin
                emit   = 1'b1;
                ech    = line_mem[pos_q];
                pos_d  = pos_q + 5'd1;
                k_d    = k_q + 6'd1;
                done_d = done_q + 6'd1;
              end else if ((i_q + 5'd1) < wil_q) begin
                i_d    = i_q + 5'd1;
                ph_d   = PH_GAP;
                gcnt_d = 6'd1 + (full_q ? ({1'b0, base_q} + {5'd0, i_q < rem_q}) : 6'd0);
              end else begin
                ph_d = PH_PAD;
              end
            end
            PH_GAP: begin
              emit   = 1'b1;
              done_d = done_q + 6'd1;
              gcnt_d = gcnt_q - 6'd1;
              if (gcnt_q == 6'd1) begin
                ph_d = PH_WORD;
                k_d  = '0;
              end
            end
            PH_PAD: begin
              if (done_q < total_q) begin
                emit   = 1'b1;
                done_d = done_q + 6'd1;
              end else begin
                wil_d   = '0;
                used_d  = '0;
                chars_d = '0;
                trunc_d = 1'b0;
                k_d     = '0;
                st_d    = just_q ? S_COPY : S_IDLE;
              end
            end
            default: ph_d = PH_PAD;
          endcase
        end
      end
      default: st_d = S_IDLE;
    endcase

    // Line setup for the divider: spare room, line length, base gap share and justify flag.
    if (st_d == S_DIV && st_q != S_DIV) begin
      rem_d   = (width_i > used_d) ? 5'(width_i - used_d) : 5'd0;
      total_d = (width_i > used_d) ? width_i : used_d;
      base_d  = '0;
      full_d  = just_d && (wil_d > 5'd1);
    end

    ov_d    = emit ? 1'b1 : (out_ready_i ? 1'b0 : ov_q);
    och_d   = emit ? ech : och_q;
    ole_d   = emit ? le : ole_q;
    olast_d = emit ? (le && !(just_q && te_q)) : olast_q;
    otr_d   = emit ? trunc_q : otr_q;
  end

  always_ff @(posedge clk_i) begin
    if (word_wr) begin
      word_mem[wlen_q[PosBits-1:0]] <= item_i.ch;
    end
    if (line_wr) begin
      line_mem[chars_q[PosBits-1:0] + k_q[PosBits-1:0]] <= word_mem[k_q[PosBits-1:0]];
    end
    if (len_wr) begin
      len_mem[wil_q[WordBits-1:0]] <= wl_q;
    end
    och_q   <= och_d;
    ole_q   <= ole_d;
    olast_q <= olast_d;
    otr_q   <= otr_d;
    wl_q    <= wl_d;
    k_q     <= k_d;
    gcnt_q  <= gcnt_d;
    done_q  <= done_d;
    total_q <= total_d;
    i_q     <= i_d;
    rem_q   <= rem_d;
    base_q  <= base_d;
    pos_q   <= pos_d;
    te_q    <= te_d;
    just_q  <= just_d;
    full_q  <= full_d;
    ph_q    <= ph_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      ov_q    <= 1'b0;
      wlen_q  <= '0;
      used_q  <= '0;
      chars_q <= '0;
      wil_q   <= '0;
      cut_q   <= 1'b0;
      trunc_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      ov_q    <= ov_d;
      wlen_q  <= wlen_d;
      used_q  <= used_d;
      chars_q <= chars_d;
      wil_q   <= wil_d;
      cut_q   <= cut_d;
      trunc_q <= trunc_d;
    end
  end

endmodule

[rtl/greedy_text_full_justifier.sv]
// Channel   Dir  tdata            tuser                         tlast
// s_axis    in   word_char[7:0]   word_end[0]                   text_end
// m_axis    out  out_char[7:0]    line_end[0], word_truncated[1] run_last
// cfg       in   line_width[5:0]  -                             -
// The queue accepts a request whenever it has a free entry, and the back end
// stores one character per cycle while it collects a word. At a word end the
// word is copied into the line buffer, after the current line is sent out if
// the word does not fit; before a line is sent, the divider spreads its spare room.
// Reset sets line_width to 16 and empties the line. A stalled output holds
// the sequencer; a two-entry queue keeps taking input until it is full.
module greedy_text_full_justifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // word_char
  input  logic [0:0]  s_axis_tuser_i,   // word_end
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // out_char
  output logic [1:0]  m_axis_tuser_o,   // line_end, word_truncated
  output logic        m_axis_tlast_o
);
  import gtj_pkg::*;

  logic [WidthBits-1:0] width_q, width_d, eff_w;
  item_t       item;
  queue_ctrl_t qc;
  logic        pop;

  assign width_d = cfg_we_i ? cfg_wdata_i : width_q;

  always_comb begin
    if (width_q == '0) begin
      eff_w = 6'd1;
    end else if (width_q > 6'(LineMax)) begin
      eff_w = 6'(LineMax);
    end else begin
      eff_w = width_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthReset;
    end else begin
      width_q <= width_d;
    end
  end

  gtj_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_char_i     (s_axis_tdata_i),
    .in_word_end_i (s_axis_tuser_i[0]),
    .in_text_end_i (s_axis_tlast_i),
    .pop_i         (pop),
    .item_valid_o  (qc.valid),
    .item_o        (item)
  );

  gtj_back u_back (
    .clk_i,
    .rst_ni,
    .width_i        (eff_w),
    .q_i            (qc),
    .pop_o          (pop),
    .item_i         (item),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_char_o     (m_axis_tdata_o),
    .out_line_end_o (m_axis_tuser_o[0]),
    .out_last_o     (m_axis_tlast_o),
    .out_trunc_o    (m_axis_tuser_o[1])
  );

endmodule

[rtl/gtj_checker.sv]
module gtj_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic [1:0] m_axis_tuser_o,
  input logic       m_axis_tlast_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("Stalled output request changed.");

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o[0])
    else $error("Run ended inside a line.");

  a_trunc_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tuser_o[0]
    |=> !m_axis_tvalid_o || (m_axis_tuser_o[1] == $past(m_axis_tuser_o[1])))
    else $error("Truncation flag changed within a line.");

endmodule

bind greedy_text_full_justifier gtj_checker u_gtj_checker (
  .clk_i,
  .rst_ni,
  .m_axis_tvalid_o,
  .m_axis_tready_i,
  .m_axis_tdata_o,
  .m_axis_tuser_o,
  .m_axis_tlast_o
);
